[rtl/core/cpu8_pkg.sv]
// Shared types, opcode codes and ALU helpers for the 8-bit register step unit.
`timescale 1ns / 1ps
`default_nettype none
package cpu8_pkg;

	typedef enum logic [5:0] {
		OP_ADD  = 6'd0,
		OP_ADC  = 6'd1,
		OP_SUB  = 6'd2,
		OP_SBB  = 6'd3,
		OP_ANA  = 6'd4,
		OP_XRA  = 6'd5,
		OP_ORA  = 6'd6,
		OP_CMP  = 6'd7,
		OP_ADI  = 6'd8,
		OP_ACI  = 6'd9,
		OP_SUI  = 6'd10,
		OP_SBI  = 6'd11,
		OP_ANI  = 6'd12,
		OP_XRI  = 6'd13,
		OP_ORI  = 6'd14,
		OP_CPI  = 6'd15,
		OP_INR  = 6'd16,
		OP_DCR  = 6'd17,
		OP_INX  = 6'd18,
		OP_DCX  = 6'd19,
		OP_DAD  = 6'd20,
		OP_RLC  = 6'd21,
		OP_RRC  = 6'd22,
		OP_RAL  = 6'd23,
		OP_RAR  = 6'd24,
		OP_CMA  = 6'd25,
		OP_CMC  = 6'd26,
		OP_STC  = 6'd27,
		OP_MOV  = 6'd28,
		OP_MVI  = 6'd29,
		OP_LXI  = 6'd30,
		OP_XCHG = 6'd31,
		OP_SPHL = 6'd32
	} op_t;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_ADC = 3'd1,
		ALU_SUB = 3'd2,
		ALU_SBB = 3'd3,
		ALU_ANA = 3'd4,
		ALU_XRA = 3'd5,
		ALU_ORA = 3'd6,
		ALU_CMP = 3'd7
	} alu_op_t;

	typedef enum logic [2:0] {
		SEL_B = 3'd0,
		SEL_C = 3'd1,
		SEL_D = 3'd2,
		SEL_E = 3'd3,
		SEL_H = 3'd4,
		SEL_L = 3'd5,
		SEL_M = 3'd6,
		SEL_A = 3'd7
	} sel_t;

	typedef enum logic [1:0] {
		RP_BC = 2'd0,
		RP_DE = 2'd1,
		RP_HL = 2'd2,
		RP_SP = 2'd3
	} rp_t;

	// opcode bits above this field select the ALU group
	localparam int unsigned ALU_GRP_W = 3;
	localparam logic [2:0]  GRP_REG   = 3'd0;
	localparam logic [2:0]  GRP_IMM   = 3'd1;

	typedef struct packed {
		logic [7:0] res;
		logic       cy;
	} alu_res_t;

	function automatic alu_res_t alu8(input alu_op_t k, input logic [7:0] a,
		input logic [7:0] b, input logic cy);
		alu_res_t   r;
		logic [8:0] t;
		begin
			t = 9'd0;
			case (k)
				ALU_ADD: t = {1'b0, a} + {1'b0, b};
				ALU_ADC: t = {1'b0, a} + {1'b0, b} + {8'd0, cy};
				ALU_SUB, ALU_CMP: t = {1'b0, a} - {1'b0, b};
				ALU_SBB: t = {1'b0, a} - {1'b0, b} - {8'd0, cy};
				ALU_ANA: t = {1'b0, a & b};
				ALU_XRA: t = {1'b0, a ^ b};
				ALU_ORA: t = {1'b0, a | b};
				default: t = {1'b0, a};
			endcase
			r.res = t[7:0];
			r.cy  = t[8];
			return r;
		end
	endfunction

	function automatic logic parity_even(input logic [7:0] r);
		return ~(^r);
	endfunction

endpackage
`default_nettype wire

[rtl/core/cpu8_in_if.sv]
// Instruction channel: valid/ready handshake with the decoded instruction fields.
`timescale 1ns / 1ps
`default_nettype none
interface cpu8_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  opcode;
	logic [2:0]  src_reg;
	logic [2:0]  dst_reg;
	logic [1:0]  reg_pair;
	logic [15:0] immediate;
	logic [7:0]  mem_data;

	modport source (output valid, opcode, src_reg, dst_reg, reg_pair, immediate, mem_data,
		input ready);
	modport sink (input valid, opcode, src_reg, dst_reg, reg_pair, immediate, mem_data,
		output ready);
endinterface
`default_nettype wire

[rtl/core/cpu8_out_if.sv]
// Result channel: valid/ready handshake with accumulator, flags, memory write and pairs.
`timescale 1ns / 1ps
`default_nettype none
interface cpu8_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  acc_out;
	logic        carry_out;
	logic        zero_out;
	logic        sign_out;
	logic        parity_out;
	logic        mem_write;
	logic [7:0]  mem_write_data;
	logic [15:0] hl_out;
	logic [15:0] bc_out;
	logic [15:0] de_out;
	logic [15:0] sp_out;

	modport source (output valid, acc_out, carry_out, zero_out, sign_out, parity_out,
		mem_write, mem_write_data, hl_out, bc_out, de_out, sp_out, input ready);
	modport sink (input valid, acc_out, carry_out, zero_out, sign_out, parity_out,
		mem_write, mem_write_data, hl_out, bc_out, de_out, sp_out, output ready);
endinterface
`default_nettype wire

[rtl/core/cpu8_alu_register_step.sv]
// An instruction transfer is captured in the input register. Throughput: one
// instruction per cycle when not stalled; the input register feeds one pass of
// ALU and register-file logic whose result lands in the output register.
// A stall on the result side holds the input register until the output frees.
// Reset clears A, B, C, D, E, H, L, SP, all flags and both valid bits.
`timescale 1ns / 1ps
`default_nettype none
module cpu8_alu_register_step
	import cpu8_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	cpu8_in_if.sink     item,
	cpu8_out_if.source  result
);

	logic        vld_s1;
	logic [5:0]  op_s1;
	logic [2:0]  src_s1;
	logic [2:0]  dst_s1;
	logic [1:0]  rp_s1;
	logic [15:0] imm_s1;
	logic [7:0]  mem_s1;

	logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0] sp_q;
	logic        cy_q, z_q, s_q, p_q;

	logic        res_vld_q;
	logic        res_wr_q;
	logic [7:0]  res_wrd_q;

	logic        advance;
	logic        in_xfer;

	logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
	logic [15:0] n_sp;
	logic        n_cy, n_z, n_s, n_p;
	logic        n_wr;
	logic [7:0]  n_wrd;
	logic [7:0]  src_val, dst_val, step_val, wval;
	logic [15:0] pair_val, pair_new;
	logic [16:0] dad_sum;
	logic        pair_we;
	logic [1:0]  pair_sel;
	logic        sel_we;
	alu_res_t    alu_r;
	alu_op_t     alu_k;

	assign advance    = vld_s1 && (!res_vld_q || result.ready);
	assign item.ready = !vld_s1 || advance;
	assign in_xfer    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1  <= item.opcode;
			src_s1 <= item.src_reg;
			dst_s1 <= item.dst_reg;
			rp_s1  <= item.reg_pair;
			imm_s1 <= item.immediate;
			mem_s1 <= item.mem_data;
		end
	end

	always_comb begin
		case (sel_t'(src_s1))
			SEL_B:   src_val = b_q;
			SEL_C:   src_val = c_q;
			SEL_D:   src_val = d_q;
			SEL_E:   src_val = e_q;
			SEL_H:   src_val = h_q;
			SEL_L:   src_val = l_q;
			SEL_M:   src_val = mem_s1;
			default: src_val = a_q;
		endcase
		case (sel_t'(dst_s1))
			SEL_B:   dst_val = b_q;
			SEL_C:   dst_val = c_q;
			SEL_D:   dst_val = d_q;
			SEL_E:   dst_val = e_q;
			SEL_H:   dst_val = h_q;
			SEL_L:   dst_val = l_q;
			SEL_M:   dst_val = mem_s1;
			default: dst_val = a_q;
		endcase
		case (rp_t'(rp_s1))
			RP_BC:   pair_val = {b_q, c_q};
			RP_DE:   pair_val = {d_q, e_q};
			RP_HL:   pair_val = {h_q, l_q};
			default: pair_val = sp_q;
		endcase
	end

	always_comb begin
		n_a = a_q; n_b = b_q; n_c = c_q; n_d = d_q; n_e = e_q; n_h = h_q; n_l = l_q;
		n_sp = sp_q;
		n_cy = cy_q; n_z = z_q; n_s = s_q; n_p = p_q;
		n_wr = 1'b0;
		n_wrd = 8'd0;
		sel_we = 1'b0;
		wval = 8'd0;
		pair_we = 1'b0;
		pair_sel = rp_s1;
		pair_new = 16'd0;
		alu_k = alu_op_t'(op_s1[ALU_GRP_W-1:0]);
		alu_r = alu8(alu_k, a_q,
			(op_s1[5:ALU_GRP_W] == GRP_IMM) ? imm_s1[7:0] : src_val, cy_q);
		step_val = (op_t'(op_s1) == OP_INR) ? dst_val + 8'd1 : dst_val - 8'd1;
		dad_sum = {1'b0, h_q, l_q} + {1'b0, pair_val};

		if (op_s1[5:ALU_GRP_W] == GRP_REG || op_s1[5:ALU_GRP_W] == GRP_IMM) begin
			n_cy = alu_r.cy;
			n_z  = (alu_r.res == 8'd0);
			n_s  = alu_r.res[7];
			n_p  = parity_even(alu_r.res);
			if (alu_k != ALU_CMP) begin
				n_a = alu_r.res;
			end
		end else begin
			case (op_t'(op_s1))
				OP_INR, OP_DCR: begin
					n_z = (step_val == 8'd0);
					n_s = step_val[7];
					n_p = parity_even(step_val);
					sel_we = 1'b1;
					wval = step_val;
				end
				OP_INX: begin
					pair_we = 1'b1;
					pair_new = pair_val + 16'd1;
				end
				OP_DCX: begin
					pair_we = 1'b1;
					pair_new = pair_val - 16'd1;
				end
				OP_DAD: begin
					n_cy = dad_sum[16];
					pair_we = 1'b1;
					pair_sel = RP_HL;
					pair_new = dad_sum[15:0];
				end
				OP_RLC: begin
					n_a = {a_q[6:0], a_q[7]};
					n_cy = a_q[7];
				end
				OP_RRC: begin
					n_a = {a_q[0], a_q[7:1]};
					n_cy = a_q[0];
				end
				OP_RAL: begin
					n_a = {a_q[6:0], cy_q};
					n_cy = a_q[7];
				end
				OP_RAR: begin
					n_a = {cy_q, a_q[7:1]};
					n_cy = a_q[0];
				end
				OP_CMA: n_a = ~a_q;
				OP_CMC: n_cy = ~cy_q;
				OP_STC: n_cy = 1'b1;
				OP_MOV: begin
					sel_we = 1'b1;
					wval = src_val;
				end
				OP_MVI: begin
					sel_we = 1'b1;
					wval = imm_s1[7:0];
				end
				OP_LXI: begin
					pair_we = 1'b1;
					pair_new = imm_s1;
				end
				OP_XCHG: begin
					n_h = d_q; n_l = e_q; n_d = h_q; n_e = l_q;
				end
				OP_SPHL: n_sp = {h_q, l_q};
				default: ;
			endcase
		end

		if (sel_we) begin
			case (sel_t'(dst_s1))
				SEL_B: n_b = wval;
				SEL_C: n_c = wval;
				SEL_D: n_d = wval;
				SEL_E: n_e = wval;
				SEL_H: n_h = wval;
				SEL_L: n_l = wval;
				SEL_M: begin
					n_wr = 1'b1;
					n_wrd = wval;
				end
				default: n_a = wval;
			endcase
		end

		if (pair_we) begin
			case (rp_t'(pair_sel))
				RP_BC: begin
					n_b = pair_new[15:8]; n_c = pair_new[7:0];
				end
				RP_DE: begin
					n_d = pair_new[15:8]; n_e = pair_new[7:0];
				end
				RP_HL: begin
					n_h = pair_new[15:8]; n_l = pair_new[7:0];
				end
				default: n_sp = pair_new;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; b_q <= 8'd0; c_q <= 8'd0; d_q <= 8'd0;
			e_q <= 8'd0; h_q <= 8'd0; l_q <= 8'd0;
			sp_q <= 16'd0;
			cy_q <= 1'b0; z_q <= 1'b0; s_q <= 1'b0; p_q <= 1'b0;
		end else if (advance) begin
			a_q <= n_a; b_q <= n_b; c_q <= n_c; d_q <= n_d;
			e_q <= n_e; h_q <= n_h; l_q <= n_l;
			sp_q <= n_sp;
			cy_q <= n_cy; z_q <= n_z; s_q <= n_s; p_q <= n_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_wr_q  <= n_wr;
			res_wrd_q <= n_wrd;
		end
	end

	// architectural registers hold the state seen by the pending result
	assign result.valid          = res_vld_q;
	assign result.acc_out        = a_q;
	assign result.carry_out      = cy_q;
	assign result.zero_out       = z_q;
	assign result.sign_out       = s_q;
	assign result.parity_out     = p_q;
	assign result.mem_write      = res_wr_q;
	assign result.mem_write_data = res_wrd_q;
	assign result.hl_out         = {h_q, l_q};
	assign result.bc_out         = {b_q, c_q};
	assign result.de_out         = {d_q, e_q};
	assign result.sp_out         = sp_q;

endmodule
`default_nettype wire
